/* rtl/core/neighbour_presence_table_defines.svh */
// Assertion macros shared by the neighbour presence table RTL.
`ifndef NEIGHBOUR_PRESENCE_TABLE_DEFINES_SVH
`define NEIGHBOUR_PRESENCE_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define NPT_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled during reset.
`define NPT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/npt_pkg.sv */
// Package with types, codes and reset values of the neighbour presence table.
`timescale 1ns / 1ps

package npt_pkg;

    localparam int NPT_MAX_ENTRIES = 8;
    localparam int CFG_IDX_W       = 3;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_INSERTED = 3'd1,
        EV_DETECT   = 3'd2,
        EV_ABSENT   = 3'd3,
        EV_FULL     = 3'd4
    } event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RSSI_THRESHOLD  = 3'd0,
        REG_DETECT_TICKS    = 3'd1,
        REG_RESEND_TICKS    = 3'd2,
        REG_ABSENT_TICKS    = 3'd3,
        REG_EXPECTED_LENGTH = 3'd4
    } cfg_reg_t;

    localparam logic signed [7:0] RST_RSSI_THRESHOLD  = -8'sd65;
    localparam logic [31:0]       RST_DETECT_TICKS    = 32'd256;
    localparam logic [31:0]       RST_RESEND_TICKS    = 32'd3840;
    localparam logic [31:0]       RST_ABSENT_TICKS    = 32'd1280;
    localparam logic [15:0]       RST_EXPECTED_LENGTH = 16'd12;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] near_since;
        logic [31:0] away_since;
        logic [31:0] last_report;
    } entry_t;

endpackage

/* rtl/core/npt_ifs.sv */
// Channel interfaces of the neighbour presence table: beacons, results and configuration.
`timescale 1ns / 1ps

interface npt_beacon_if;
    logic               valid;
    logic               ready;
    logic [15:0]        packet_length;
    logic [31:0]        neighbour_id;
    logic [63:0]        sender_address;
    logic signed [7:0]  rssi;
    logic [31:0]        now;

    modport source (
        output valid, packet_length, neighbour_id, sender_address, rssi, now,
        input  ready
    );
    modport sink (
        input  valid, packet_length, neighbour_id, sender_address, rssi, now,
        output ready
    );
endinterface

interface npt_result_if;
    logic        valid;
    logic        ready;
    logic [2:0]  event_res;
    logic [2:0]  entry_index;
    logic [31:0] event_time;
    logic [63:0] reply_address;
    logic [31:0] reported_id;

    modport source (
        output valid, event_res, entry_index, event_time, reply_address, reported_id,
        input  ready
    );
    modport sink (
        input  valid, event_res, entry_index, event_time, reply_address, reported_id,
        output ready
    );
endinterface

interface npt_cfg_if import npt_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

/* rtl/core/npt_entry_ram.sv */
// Neighbour entry memory with one write port and one registered read port.
`timescale 1ns / 1ps

module npt_entry_ram import npt_pkg::*; #(
    parameter int DEPTH = NPT_MAX_ENTRIES,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  entry_t        wdata,
    input  logic [AW-1:0] raddr,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/npt_cmp_unit.sv */
// Shared unit that registers whether a wrapping time difference reaches a limit.
`timescale 1ns / 1ps

module npt_cmp_unit (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    input  logic [31:0] lim,
    output logic        ge
);

    logic [31:0] diff;
    logic        ge_reg;

    assign diff = a - b;

    always_ff @(posedge clk)
    begin
        ge_reg <= (diff >= lim);
    end

    assign ge = ge_reg;

endmodule

/* rtl/core/neighbour_presence_table.sv */
// Top level of the neighbour presence table.
`timescale 1ns / 1ps
`include "neighbour_presence_table_defines.svh"

// One beacon is handled at a time. After acceptance the entry memory is scanned
// one entry per cycle until the neighbour is found or the filled entries run out;
// a beacon of the wrong length skips the scan. The entry memory has one write port
// and one registered read port, and a found entry makes two passes through one
// shared subtract-and-compare unit. The result sits in an output register, so the
// next beacon is taken while it waits. Configuration writes are taken in every cycle.
module neighbour_presence_table import npt_pkg::*; #(
    parameter int MAX_ENTRIES = NPT_MAX_ENTRIES
) (
    input  logic clk,
    input  logic rst_n,
    npt_beacon_if.sink   beacon,
    npt_result_if.source result,
    npt_cfg_if.sink      cfg
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int EXT_W = (IDX_W >= 3) ? IDX_W : 3;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_SCAN  = 8'b0000_0010,
        S_MISS  = 8'b0000_0100,
        S_FIX   = 8'b0000_1000,
        S_CMP_A = 8'b0001_0000,
        S_CMP_B = 8'b0010_0000,
        S_WB    = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [IDX_W-1:0]  scan_reg, scan_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              out_valid_reg, out_valid_next;

    logic signed [7:0] thresh_reg;
    logic [31:0]       detect_reg;
    logic [31:0]       resend_reg;
    logic [31:0]       absent_reg;
    logic [15:0]       length_reg;

    logic              near_reg, near_next;
    logic [31:0]       id_reg, id_next;
    logic [63:0]       addr_reg, addr_next;
    logic [31:0]       now_reg, now_next;
    entry_t            entry_reg, entry_next;
    logic              cmp_a_reg, cmp_a_next;

    event_t            res_event_reg, res_event_next;
    logic [2:0]        res_index_reg, res_index_next;
    logic [31:0]       res_time_reg, res_time_next;
    logic [63:0]       res_addr_reg, res_addr_next;
    logic [31:0]       res_id_reg, res_id_next;

    event_t            out_event_reg;
    logic [2:0]        out_index_reg;
    logic [31:0]       out_time_reg;
    logic [63:0]       out_addr_reg;
    logic [31:0]       out_id_reg;
    logic              out_load;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    entry_t            ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    entry_t            ram_rdata;

    logic [31:0]       cmp_a_in, cmp_b_in, cmp_lim;
    logic              cmp_ge;

    logic [EXT_W-1:0]  slot_wide, count_wide;

    assign slot_wide  = EXT_W'(slot_reg);
    assign count_wide = EXT_W'(count_reg);

    npt_entry_ram #(
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    npt_cmp_unit u_cmp (
        .clk (clk),
        .a   (cmp_a_in),
        .b   (cmp_b_in),
        .lim (cmp_lim),
        .ge  (cmp_ge)
    );

    assign beacon.ready = (state_reg == S_IDLE);
    assign cfg.ready    = 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        slot_next      = slot_reg;
        near_next      = near_reg;
        id_next        = id_reg;
        addr_next      = addr_reg;
        now_next       = now_reg;
        entry_next     = entry_reg;
        cmp_a_next     = cmp_a_reg;
        res_event_next = res_event_reg;
        res_index_next = res_index_reg;
        res_time_next  = res_time_reg;
        res_addr_next  = res_addr_reg;
        res_id_next    = res_id_reg;
        out_load       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = slot_reg;
        ram_wdata      = entry_reg;
        ram_raddr      = '0;
        cmp_a_in       = now_reg;
        cmp_b_in       = entry_reg.last_report;
        cmp_lim        = resend_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (beacon.valid)
                begin
                    id_next        = beacon.neighbour_id;
                    addr_next      = beacon.sender_address;
                    now_next       = beacon.now;
                    near_next      = (beacon.rssi > thresh_reg);
                    scan_next      = '0;
                    res_event_next = EV_NONE;
                    res_index_next = '0;
                    res_time_next  = '0;
                    res_addr_next  = '0;
                    res_id_next    = '0;
                    if (beacon.packet_length != length_reg)
                    begin
                        state_next = S_DONE;
                    end
                    else if (count_reg == '0)
                    begin
                        state_next = S_MISS;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (ram_rdata.id == id_reg)
                begin
                    slot_next  = scan_reg;
                    entry_next = ram_rdata;
                    state_next = S_FIX;
                end
                else if (CNT_W'(scan_reg) + CNT_W'(1) == count_reg)
                begin
                    state_next = S_MISS;
                end
                else
                begin
                    scan_next = IDX_W'(scan_reg + 1'b1);
                    ram_raddr = IDX_W'(scan_reg + 1'b1);
                end
            end
            S_MISS:
            begin
                res_id_next = id_reg;
                if (count_reg == CNT_W'(MAX_ENTRIES))
                begin
                    res_event_next = EV_FULL;
                end
                else
                begin
                    ram_we                = 1'b1;
                    ram_waddr             = IDX_W'(count_reg);
                    ram_wdata.id          = id_reg;
                    ram_wdata.near_since  = near_reg ? now_reg : 32'd0;
                    ram_wdata.away_since  = near_reg ? 32'd0 : now_reg;
                    ram_wdata.last_report = 32'd0;
                    count_next            = count_reg + CNT_W'(1);
                    res_event_next        = EV_INSERTED;
                    res_index_next        = count_wide[2:0];
                end
                state_next = S_DONE;
            end
            S_FIX:
            begin
                if (near_reg)
                begin
                    if (entry_reg.near_since == 32'd0)
                    begin
                        entry_next.near_since  = now_reg;
                        entry_next.last_report = 32'd0;
                    end
                end
                else if (entry_reg.away_since == 32'd0)
                begin
                    entry_next.away_since = now_reg;
                end
                state_next = S_CMP_A;
            end
            S_CMP_A:
            begin
                cmp_b_in   = near_reg ? entry_reg.near_since : entry_reg.away_since;
                cmp_lim    = near_reg ? detect_reg : absent_reg;
                state_next = S_CMP_B;
            end
            S_CMP_B:
            begin
                cmp_a_next = cmp_ge;
                state_next = S_WB;
            end
            S_WB:
            begin
                ram_we = 1'b1;
                if (near_reg)
                begin
                    if (cmp_a_reg && (entry_reg.last_report == 32'd0 || cmp_ge))
                    begin
                        ram_wdata.last_report = now_reg;
                        res_event_next        = EV_DETECT;
                        res_index_next        = slot_wide[2:0];
                        res_time_next         = entry_reg.near_since;
                        res_addr_next         = addr_reg;
                        res_id_next           = id_reg;
                    end
                end
                else if (cmp_a_reg && entry_reg.near_since != 32'd0
                         && entry_reg.away_since != 32'd0)
                begin
                    ram_wdata.near_since = 32'd0;
                    ram_wdata.away_since = 32'd0;
                    res_event_next       = EV_ABSENT;
                    res_index_next       = slot_wide[2:0];
                    res_time_next        = entry_reg.away_since;
                    res_id_next          = id_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            scan_reg      <= '0;
            out_valid_reg <= 1'b0;
            thresh_reg    <= RST_RSSI_THRESHOLD;
            detect_reg    <= RST_DETECT_TICKS;
            resend_reg    <= RST_RESEND_TICKS;
            absent_reg    <= RST_ABSENT_TICKS;
            length_reg    <= RST_EXPECTED_LENGTH;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            scan_reg      <= scan_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_RSSI_THRESHOLD:  thresh_reg <= $signed(cfg.data[7:0]);
                    REG_DETECT_TICKS:    detect_reg <= cfg.data;
                    REG_RESEND_TICKS:    resend_reg <= cfg.data;
                    REG_ABSENT_TICKS:    absent_reg <= cfg.data;
                    REG_EXPECTED_LENGTH: length_reg <= cfg.data[15:0];
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        near_reg      <= near_next;
        id_reg        <= id_next;
        addr_reg      <= addr_next;
        now_reg       <= now_next;
        entry_reg     <= entry_next;
        cmp_a_reg     <= cmp_a_next;
        res_event_reg <= res_event_next;
        res_index_reg <= res_index_next;
        res_time_reg  <= res_time_next;
        res_addr_reg  <= res_addr_next;
        res_id_reg    <= res_id_next;
        if (out_load)
        begin
            out_event_reg <= res_event_reg;
            out_index_reg <= res_index_reg;
            out_time_reg  <= res_time_reg;
            out_addr_reg  <= res_addr_reg;
            out_id_reg    <= res_id_reg;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.event_res     = out_event_reg;
    assign result.entry_index   = out_index_reg;
    assign result.event_time    = out_time_reg;
    assign result.reply_address = out_addr_reg;
    assign result.reported_id   = out_id_reg;

    `NPT_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_ENTRIES), "Entry count beyond table depth.")
    `NPT_ASSERT_SAME(a_scan_range, state_reg == S_SCAN, CNT_W'(scan_reg) < count_reg, "Scan beyond filled entries.")
    `NPT_ASSERT_NEXT(a_full_count, (state_reg == S_MISS) && (count_reg == CNT_W'(MAX_ENTRIES)), count_reg == $past(count_reg), "Full table changed its count.")
    `NPT_ASSERT_NEXT(a_event_cmp, (state_reg == S_WB) && !cmp_a_reg, (res_event_reg != EV_DETECT) && (res_event_reg != EV_ABSENT), "Event without elapsed time.")

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench of the neighbour presence table: random beacons, register phases and handshake gaps.
`timescale 1ns / 1ps

module tb_top;
    import npt_pkg::*;

    localparam int HALF_PERIOD       = 5;
    localparam int QUIET_LIMIT       = 5000;
    localparam int PHASES            = 9;
    localparam int BEACONS_PER_PHASE = 150;
    localparam int DIRECTED_BEACONS  = 25;
    localparam int LONG_HOLD         = 300;
    localparam int HOLD_AFTER        = 200;
    localparam int DRAIN_CYCLES      = 20;

    typedef struct {
        logic [15:0]       len;
        logic [31:0]       id;
        logic [63:0]       addr;
        logic signed [7:0] rssi;
        logic [31:0]       now;
    } beacon_t;

    typedef struct {
        event_t      ev;
        logic [2:0]  slot;
        logic [31:0] stamp;
        logic [63:0] addr;
        logic [31:0] id;
    } presence_event_t;

    logic clk = 1'b0;
    logic rst_n;

    npt_beacon_if beacon_ch ();
    npt_result_if result_ch ();
    npt_cfg_if    cfg_ch ();

    neighbour_presence_table DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .beacon (beacon_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    logic signed [7:0] cur_rssi_thr = RST_RSSI_THRESHOLD;
    logic [31:0]       cur_detect   = RST_DETECT_TICKS;
    logic [31:0]       cur_resend   = RST_RESEND_TICKS;
    logic [31:0]       cur_absent   = RST_ABSENT_TICKS;
    logic [15:0]       cur_len      = RST_EXPECTED_LENGTH;

    logic [31:0] tbl_id   [NPT_MAX_ENTRIES];
    logic [31:0] tbl_near [NPT_MAX_ENTRIES];
    logic [31:0] tbl_away [NPT_MAX_ENTRIES];
    logic [31:0] tbl_last [NPT_MAX_ENTRIES];
    int unsigned tbl_count = 0;

    beacon_t         pending_beacons [$];
    presence_event_t expected_events [$];
    beacon_t         in_flight;

    int          send_gap;
    int          stall_left;
    int          hold_left;
    bit          long_hold_done;
    bit          no_idle = 1'b0;
    int unsigned results_seen;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;

    always #HALF_PERIOD clk = ~clk;

    function automatic presence_event_t predict_beacon(beacon_t b);
        presence_event_t r;
        int              i;
        int              slot;
        bit              found;
        bit              near;
        logic [31:0]     span;
        logic [31:0]     since_report;
        r = '{EV_NONE, 3'd0, 32'd0, 64'd0, 32'd0};
        if (b.len != cur_len)
            return r;
        near  = (b.rssi > cur_rssi_thr);
        found = 1'b0;
        slot  = 0;
        for (i = 0; i < tbl_count; i++)
        begin
            if (!found && tbl_id[i] == b.id)
            begin
                slot  = i;
                found = 1'b1;
            end
        end
        if (!found)
        begin
            if (tbl_count >= NPT_MAX_ENTRIES)
            begin
                r.ev = EV_FULL;
                r.id = b.id;
                return r;
            end
            slot           = tbl_count;
            tbl_id[slot]   = b.id;
            tbl_near[slot] = near ? b.now : 32'd0;
            tbl_away[slot] = near ? 32'd0 : b.now;
            tbl_last[slot] = 32'd0;
            tbl_count++;
            r.ev   = EV_INSERTED;
            r.slot = 3'(slot);
            r.id   = b.id;
            return r;
        end
        if (near)
        begin
            if (tbl_near[slot] == 32'd0)
            begin
                tbl_near[slot] = b.now;
                tbl_last[slot] = 32'd0;
            end
            span         = b.now - tbl_near[slot];
            since_report = b.now - tbl_last[slot];
            if (span >= cur_detect && (tbl_last[slot] == 32'd0 || since_report >= cur_resend))
            begin
                r.ev           = EV_DETECT;
                r.slot         = 3'(slot);
                r.stamp        = tbl_near[slot];
                r.addr         = b.addr;
                r.id           = b.id;
                tbl_last[slot] = b.now;
            end
        end
        else
        begin
            if (tbl_away[slot] == 32'd0)
                tbl_away[slot] = b.now;
            span = b.now - tbl_away[slot];
            if (span >= cur_absent && tbl_near[slot] != 32'd0 && tbl_away[slot] != 32'd0)
            begin
                r.ev           = EV_ABSENT;
                r.slot         = 3'(slot);
                r.stamp        = tbl_away[slot];
                r.id           = b.id;
                tbl_near[slot] = 32'd0;
                tbl_away[slot] = 32'd0;
            end
        end
        return r;
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 15);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [7:0] draw_rssi(bit want_near);
        int t;
        t = cur_rssi_thr;
        if (want_near && t < 127)
            return 8'(t + 1 + int'($urandom_range(0, 126 - t)));
        return 8'(-128 + int'($urandom_range(0, t + 128)));
    endfunction

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    task automatic queue_beacon(logic [15:0] len, logic [31:0] id, logic [63:0] addr,
                                logic signed [7:0] rssi, logic [31:0] now);
        beacon_t b;
        b.len  = len;
        b.id   = id;
        b.addr = addr;
        b.rssi = rssi;
        b.now  = now;
        pending_beacons.push_back(b);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        case (idx)
            REG_RSSI_THRESHOLD:  cur_rssi_thr = val[7:0];
            REG_DETECT_TICKS:    cur_detect   = val;
            REG_RESEND_TICKS:    cur_resend   = val;
            REG_ABSENT_TICKS:    cur_absent   = val;
            REG_EXPECTED_LENGTH: cur_len      = val[15:0];
            default: ;
        endcase
    endtask

    task automatic program_regs(logic signed [7:0] thr, logic [31:0] det, logic [31:0] res,
                                logic [31:0] abs_ticks, logic [15:0] len);
        @(posedge clk);
        write_reg(REG_RSSI_THRESHOLD, 32'(thr));
        write_reg(REG_DETECT_TICKS, det);
        write_reg(REG_RESEND_TICKS, res);
        write_reg(REG_ABSENT_TICKS, abs_ticks);
        write_reg(REG_EXPECTED_LENGTH, 32'(len));
        cfg_ch.valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_beacons.size() != 0 || beacon_ch.valid || expected_events.size() != 0);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beacon_ch.valid          <= 1'b0;
            beacon_ch.packet_length  <= '0;
            beacon_ch.neighbour_id   <= '0;
            beacon_ch.sender_address <= '0;
            beacon_ch.rssi           <= '0;
            beacon_ch.now            <= '0;
            send_gap = 0;
        end
        else
        begin
            if (beacon_ch.valid && beacon_ch.ready)
            begin
                expected_events.push_back(predict_beacon(in_flight));
                send_gap = no_idle ? 0 : draw_gap();
            end
            if (!beacon_ch.valid || beacon_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    beacon_ch.valid <= 1'b0;
                end
                else if (pending_beacons.size() > 0)
                begin
                    in_flight = pending_beacons.pop_front();
                    beacon_ch.valid          <= 1'b1;
                    beacon_ch.packet_length  <= in_flight.len;
                    beacon_ch.neighbour_id   <= in_flight.id;
                    beacon_ch.sender_address <= in_flight.addr;
                    beacon_ch.rssi           <= in_flight.rssi;
                    beacon_ch.now            <= in_flight.now;
                end
                else
                    beacon_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        presence_event_t want;
        if (!rst_n)
        begin
            result_ch.ready <= 1'b0;
            stall_left     = 0;
            hold_left      = 0;
            long_hold_done = 1'b0;
            results_seen   = 0;
        end
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                results_seen++;
                if (expected_events.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, expected none, actual event %0d id %0h",
                             $time, result_ch.event_res, result_ch.reported_id);
                    mismatches++;
                end
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_res", want.ev, result_ch.event_res);
                    check_field("entry_index", want.slot, result_ch.entry_index);
                    check_field("event_time", want.stamp, result_ch.event_time);
                    check_field("reply_address", want.addr, result_ch.reply_address);
                    check_field("reported_id", want.id, result_ch.reported_id);
                end
            end
            // A single long hold lets the block fill up and push back on beacons.
            if (hold_left > 0)
            begin
                hold_left--;
                result_ch.ready <= 1'b0;
            end
            else if (!long_hold_done && results_seen >= HOLD_AFTER)
            begin
                long_hold_done = 1'b1;
                hold_left      = LONG_HOLD;
                result_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (!no_idle && $urandom_range(0, 99) < 25)
                    stall_left = draw_gap();
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (beacon_ch.valid && beacon_ch.ready) || (result_ch.valid && result_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_top: FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [31:0]       clock_now;
        logic [31:0]       known_ids [NPT_MAX_ENTRIES];
        bit                id_near [NPT_MAX_ENTRIES];
        logic [63:0]       addr;
        logic signed [7:0] rs;
        int                k;
        int                r;
        int                s;
        int                n;
        int                p;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= REG_RSSI_THRESHOLD;
        cfg_ch.data  <= '0;
        rst_n        <= 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Wrong lengths, at the extremes and just below the expected one, give no event.
        queue_beacon(16'd0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'sd127, 32'hFFFF_FFFF);
        queue_beacon(16'hFFFF, 32'h0, 64'h0, -8'sd128, 32'h0);
        queue_beacon(RST_EXPECTED_LENGTH - 16'd1, 32'h1234_5678, 64'h0, 8'sd0, 32'd500);
        // Fill the table: near, away, near at time zero and RSSI equal to the threshold.
        known_ids[0] = 32'h0;
        known_ids[1] = 32'hFFFF_FFFF;
        known_ids[2] = 32'h5A5A_A5A5;
        known_ids[3] = 32'h0BAD_CAFE;
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[0], 64'h0, 8'sd127, 32'd1000);
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[1], 64'hFFFF_FFFF_FFFF_FFFF, -8'sd128,
                     32'd1010);
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[2], 64'h0123_4567_89AB_CDEF, -8'sd64, 32'd0);
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[3], 64'hFEDC_BA98_7654_3210, -8'sd65,
                     32'd1030);
        for (k = 4; k < NPT_MAX_ENTRIES; k++)
        begin
            known_ids[k] = $urandom;
            queue_beacon(RST_EXPECTED_LENGTH, known_ids[k], {$urandom, $urandom},
                         8'($urandom_range(0, 255)), 32'd1040 + 32'(10 * k));
        end
        queue_beacon(RST_EXPECTED_LENGTH, 32'hC0FF_EE00, 64'h1, -8'sd20, 32'd1100);
        // Detect, suppressed repeat, resend, absence and re-entry for the first neighbour.
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[0], 64'hAAAA_5555_AAAA_5555, 8'sd10, 32'd1256);
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[0], 64'h2, 8'sd10, 32'd1300);
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[0], 64'h5555_AAAA_5555_AAAA, 8'sd10, 32'd5096);
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[0], 64'h3, -8'sd90, 32'd6000);
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[0], 64'h4, -8'sd90, 32'd7280);
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[0], 64'h5, 8'sd10, 32'd7300);
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[2], 64'h6, 8'sd10, 32'd7400);
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[1], 64'h7, -8'sd90, 32'd9000);
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[2], 64'h8, -8'sd90, 32'd0);
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[2], 64'h9, -8'sd90, 32'd2000);
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[2], 64'hA, -8'sd90, 32'd3300);
        // A time difference that wraps past zero.
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[1], 64'hB, 8'sd30, 32'hFFFF_FF00);
        queue_beacon(RST_EXPECTED_LENGTH, known_ids[1], 64'h8000_0000_0000_0001, 8'sd30,
                     32'h0000_0100);

        for (k = 0; k < NPT_MAX_ENTRIES; k++)
            id_near[k] = $urandom_range(0, 1);
        clock_now = 32'h0000_0200;
        for (p = 1; p <= PHASES; p++)
        begin
            if (p > 1)
            begin
                wait_drained();
                case (p)
                    2: program_regs(-8'sd128, 32'd0, 32'd0, 32'd0, 16'd0);
                    3: program_regs(8'sd127, '1, '1, '1, 16'hFFFF);
                    5: program_regs(8'(-90 + int'($urandom_range(0, 50))), '1, 32'd0, 32'd0,
                                    RST_EXPECTED_LENGTH);
                    default: program_regs(8'(-100 + int'($urandom_range(0, 60))),
                                          $urandom_range(0, 2000), $urandom_range(0, 6000),
                                          $urandom_range(0, 3000), 16'($urandom));
                endcase
                no_idle = (p % 4 == 0);
            end
            n = (p == 1) ? BEACONS_PER_PHASE - DIRECTED_BEACONS : BEACONS_PER_PHASE;
            repeat (n)
            begin
                s = $urandom_range(0, 99);
                if (s < 60)
                    clock_now += $urandom_range(0, 300);
                else if (s < 85)
                    clock_now += $urandom_range(300, 3000);
                else if (s < 92)
                    clock_now += $urandom_range(3000, 20000);
                else if (s < 96)
                    clock_now += $urandom;
                else if (s < 98)
                    clock_now = 32'd0;
                addr = {$urandom, $urandom};
                r = $urandom_range(0, 99);
                if (r < 6)
                    queue_beacon(16'($urandom), $urandom, addr, 8'($urandom), clock_now);
                else if (r < 16)
                    queue_beacon(cur_len, $urandom, addr, 8'($urandom), clock_now);
                else
                begin
                    k = $urandom_range(0, NPT_MAX_ENTRIES - 1);
                    if ($urandom_range(0, 99) < 15)
                        id_near[k] = !id_near[k];
                    if ($urandom_range(0, 9) == 0)
                        rs = 8'($urandom);
                    else
                        rs = draw_rssi(id_near[k]);
                    queue_beacon(cur_len, known_ids[k], addr, rs, clock_now);
                end
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
